// ===== hw/rtl/cbts_pkg.sv =====
package cbts_pkg;

    localparam int BAUD_W   = 22;
    localparam int CLOCK_W  = 28;
    localparam int PRESC_W  = 11;
    localparam int SEG1_W   = 5;
    localparam int SEG2_W   = 4;
    localparam int SJW_W    = 3;
    localparam int NQ_W     = 5;                 // 1 + seg1 + seg2, up to 19
    localparam int BP_W     = BAUD_W + PRESC_W;  // baud * prescaler
    localparam int PROD_W   = BP_W + NQ_W;       // baud * prescaler * quanta
    localparam int DIV_W    = PRESC_W + NQ_W;

    localparam int MAX_PRESCALER_DEF = 1024;

    localparam logic [CLOCK_W-1:0] CLOCK_48M = CLOCK_W'(48000000);
    localparam logic [CLOCK_W-1:0] CLOCK_45M = CLOCK_W'(45000000);

    localparam logic [SEG1_W-1:0] SEG1_FIRST = SEG1_W'(5);
    localparam logic [SEG1_W-1:0] SEG1_LAST  = SEG1_W'(15);
    localparam logic [SEG2_W-1:0] SEG2_FIRST = SEG2_W'(1);
    localparam logic [SEG2_W-1:0] SEG2_LAST  = SEG2_W'(3);
    localparam logic [SJW_W-1:0]  SJW_FOUND  = SJW_W'(1);

    localparam int TBL_N = 6;

    typedef struct packed {
        logic [BAUD_W-1:0]  rate;
        logic [PRESC_W-1:0] presc;
        logic [SEG1_W-1:0]  seg1;
        logic [SEG2_W-1:0]  seg2;
    } tbl_row_t;

    // rate 0 never occurs in a row with presc 0; unused 45 MHz slot is masked by valid count
    localparam tbl_row_t ROWS_48M [TBL_N] = '{
        '{BAUD_W'(1000000), PRESC_W'(3),  SEG1_W'(13), SEG2_W'(2)},
        '{BAUD_W'(800000),  PRESC_W'(4),  SEG1_W'(12), SEG2_W'(2)},
        '{BAUD_W'(500000),  PRESC_W'(6),  SEG1_W'(13), SEG2_W'(2)},
        '{BAUD_W'(250000),  PRESC_W'(12), SEG1_W'(13), SEG2_W'(2)},
        '{BAUD_W'(125000),  PRESC_W'(24), SEG1_W'(13), SEG2_W'(2)},
        '{BAUD_W'(100000),  PRESC_W'(30), SEG1_W'(13), SEG2_W'(2)}
    };

    localparam tbl_row_t ROWS_45M [TBL_N] = '{
        '{BAUD_W'(1000000), PRESC_W'(3),  SEG1_W'(12), SEG2_W'(2)},
        '{BAUD_W'(500000),  PRESC_W'(5),  SEG1_W'(15), SEG2_W'(2)},
        '{BAUD_W'(250000),  PRESC_W'(10), SEG1_W'(15), SEG2_W'(2)},
        '{BAUD_W'(125000),  PRESC_W'(20), SEG1_W'(15), SEG2_W'(2)},
        '{BAUD_W'(100000),  PRESC_W'(25), SEG1_W'(15), SEG2_W'(2)},
        '{BAUD_W'(100000),  PRESC_W'(25), SEG1_W'(15), SEG2_W'(2)}
    };

    typedef struct packed {
        logic               hit;
        logic [PRESC_W-1:0] presc;
        logic [SEG1_W-1:0]  seg1;
        logic [SEG2_W-1:0]  seg2;
    } tbl_res_t;

    typedef struct packed {
        logic [PRESC_W-1:0] presc;
        logic [SEG1_W-1:0]  seg1;
        logic [SEG2_W-1:0]  seg2;
    } cand_t;

    typedef struct packed {
        logic              valid;
        logic [BP_W-1:0]   bp;
        logic [NQ_W-1:0]   nq;
        cand_t             cand;
    } eval_req_t;

    typedef struct packed {
        logic  match;
        logic  busy;
        cand_t cand;
    } eval_rsp_t;

    // first matching row wins, as in a linear scan
    function automatic tbl_res_t table_find(input logic [CLOCK_W-1:0] clk_hz,
                                            input logic [BAUD_W-1:0]  baud);
        tbl_res_t res;
        tbl_row_t row;
        logic     is48;
        logic     is45;
        res  = '0;
        is48 = (clk_hz == CLOCK_48M);
        is45 = (clk_hz == CLOCK_45M);
        for (int i = TBL_N - 1; i >= 0; i--) begin
            row = is48 ? ROWS_48M[i] : ROWS_45M[i];
            if ((is48 || (is45 && i < TBL_N - 1)) && row.rate == baud) begin
                res.hit   = 1'b1;
                res.presc = row.presc;
                res.seg1  = row.seg1;
                res.seg2  = row.seg2;
            end
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/cbts_eval.sv =====
// Two-stage multiply/compare unit: one candidate per cycle; product and divisor are registered, then the match flag.
// Match when baud*div <= clock < (baud+1)*div, i.e. floor(clock/div) == baud.
module cbts_eval (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clear,
    input  logic [cbts_pkg::CLOCK_W-1:0]  clock_hz,
    input  cbts_pkg::eval_req_t           req,
    output cbts_pkg::eval_rsp_t           rsp
);
    import cbts_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    logic [PROD_W-1:0] prod_reg;
    logic [DIV_W-1:0]  div_reg;
    cand_t             s1_cand_reg;

    logic              s2_match_reg, s2_match_next;
    cand_t             s2_cand_reg;

    logic [PROD_W-1:0] clock_ext;
    logic [PROD_W-1:0] upper;
    logic              hit;

    assign s1_valid_next = req.valid && !clear;
    assign clock_ext     = PROD_W'(clock_hz);
    assign upper         = prod_reg + PROD_W'(div_reg);
    assign hit           = (prod_reg <= clock_ext) && (upper > clock_ext);
    assign s2_match_next = s1_valid_reg && hit && !clear;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_match_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_match_reg <= s2_match_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg    <= PROD_W'(req.bp) * PROD_W'(req.nq);
        div_reg     <= DIV_W'(req.cand.presc) * DIV_W'(req.nq);
        s1_cand_reg <= req.cand;
        s2_cand_reg <= s1_cand_reg;
    end

    assign rsp.match = s2_match_reg;
    assign rsp.busy  = s1_valid_reg || s2_match_reg;
    assign rsp.cand  = s2_cand_reg;

endmodule

// ===== hw/rtl/can_bit_timing_search.sv =====
// CAN bit timing search.
// s_ channel: one beat carries a requested bit rate (tdata[21:0]).
// m_ channel: one beat per request with prescaler, segment 1, segment 2 and
//   jump width in tdata, found flag in tuser; all timing fields are 0 when
//   nothing matches.
// cfg_wr_en/cfg_wr_data load the clock frequency in Hz; write only while idle.
// At 48 MHz or 45 MHz a fixed rate table is checked first.
// Otherwise candidates (prescaler outer, seg2, seg1 inner) go through one
//   pipelined multiply/compare unit at one candidate per cycle; the first hit
//   ends the search; when nothing matches, all 33*MAX_PRESCALER candidates are tried.
// One request at a time: s_tready is high only while the sequencer is idle;
//   the next beat can be taken in the same cycle as a result appears.
// The result sits in an output register, so the next request is accepted
//   while a result still waits; a new result waits until m_tready frees it.
// Reset clears the sequencer and output valid; clock register returns to 48 MHz.
module can_bit_timing_search #(
    parameter int MAX_PRESCALER = cbts_pkg::MAX_PRESCALER_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [cbts_pkg::CLOCK_W-1:0] cfg_wr_data,    // clock_hz
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,        // [21:0] baud_rate
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata,        // prescaler, seg_one, seg_two, jump_width
    output logic                         m_tuser         // found
);
    import cbts_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_TABLE  = 5'b00010,
        ST_SEARCH = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    localparam logic [PRESC_W-1:0] PRESC_LAST = PRESC_W'(MAX_PRESCALER);

    state_t              state_reg, state_next;
    logic [CLOCK_W-1:0]  clock_reg, clock_next;
    logic [BAUD_W-1:0]   baud_reg, baud_next;
    logic [BP_W-1:0]     bp_reg, bp_next;
    cand_t               cand_reg, cand_next;

    logic                res_found_reg, res_found_next;
    cand_t               res_cand_reg, res_cand_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_found_reg, out_found_next;
    cand_t               out_cand_reg, out_cand_next;

    tbl_res_t            tbl;
    eval_req_t           req;
    eval_rsp_t           rsp;
    logic                clear;
    logic                last_cand;
    logic                out_free;

    cbts_eval u_eval (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (clear),
        .clock_hz (clock_reg),
        .req      (req),
        .rsp      (rsp)
    );

    assign tbl       = table_find(clock_reg, baud_reg);
    assign last_cand = (cand_reg.presc == PRESC_LAST) && (cand_reg.seg2 == SEG2_LAST)
                       && (cand_reg.seg1 == SEG1_LAST);
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb begin
        req.valid = (state_reg == ST_SEARCH) && !rsp.match;
        req.bp    = bp_reg;
        req.nq    = NQ_W'(1) + NQ_W'(cand_reg.seg1) + NQ_W'(cand_reg.seg2);
        req.cand  = cand_reg;
    end

    always_comb begin
        state_next     = state_reg;
        clock_next     = cfg_wr_en ? cfg_wr_data : clock_reg;
        baud_next      = baud_reg;
        bp_next        = bp_reg;
        cand_next      = cand_reg;
        res_found_next = res_found_reg;
        res_cand_next  = res_cand_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_found_next = out_found_reg;
        out_cand_next  = out_cand_reg;
        clear          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    baud_next  = s_tdata[BAUD_W-1:0];
                    bp_next    = BP_W'(s_tdata[BAUD_W-1:0]);
                    cand_next  = '{presc: PRESC_W'(1), seg1: SEG1_FIRST, seg2: SEG2_FIRST};
                    state_next = ST_TABLE;
                end
            end
            ST_TABLE: begin
                if (tbl.hit) begin
                    res_found_next = 1'b1;
                    res_cand_next  = '{presc: tbl.presc, seg1: tbl.seg1, seg2: tbl.seg2};
                    state_next     = ST_OUT;
                end else begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH, ST_DRAIN: begin
                if (rsp.match) begin
                    clear          = 1'b1;
                    res_found_next = 1'b1;
                    res_cand_next  = rsp.cand;
                    state_next     = ST_OUT;
                end else if (state_reg == ST_DRAIN) begin
                    if (!rsp.busy) begin
                        res_found_next = 1'b0;
                        res_cand_next  = '0;
                        state_next     = ST_OUT;
                    end
                end else if (last_cand) begin
                    state_next = ST_DRAIN;
                end else if (cand_reg.seg1 != SEG1_LAST) begin
                    cand_next.seg1 = cand_reg.seg1 + SEG1_W'(1);
                end else if (cand_reg.seg2 != SEG2_LAST) begin
                    cand_next.seg1 = SEG1_FIRST;
                    cand_next.seg2 = cand_reg.seg2 + SEG2_W'(1);
                end else begin
                    cand_next.seg1  = SEG1_FIRST;
                    cand_next.seg2  = SEG2_FIRST;
                    cand_next.presc = cand_reg.presc + PRESC_W'(1);
                    bp_next         = bp_reg + BP_W'(baud_reg);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_cand_next  = res_cand_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            clock_reg     <= CLOCK_48M;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clock_reg     <= clock_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        baud_reg      <= baud_next;
        bp_reg        <= bp_next;
        cand_reg      <= cand_next;
        res_found_reg <= res_found_next;
        res_cand_reg  <= res_cand_next;
        out_found_reg <= out_found_next;
        out_cand_reg  <= out_cand_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {1'b0,
                       out_found_reg ? SJW_FOUND : SJW_W'(0),
                       out_cand_reg.seg2,
                       out_cand_reg.seg1,
                       out_cand_reg.presc};

endmodule

// ===== bench/cbts_timing_checker.sv =====
module cbts_timing_checker #(
    parameter int MAX_PRESC = cbts_pkg::MAX_PRESCALER_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [cbts_pkg::CLOCK_W-1:0] cfg_wr_data,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [23:0]                  s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [23:0]                  m_tdata,
    input  logic                         m_tuser,
    output int                           pending,
    output int                           fail_count
);
    import cbts_pkg::*;

    typedef struct packed {
        logic               found;
        logic [PRESC_W-1:0] presc;
        logic [SEG1_W-1:0]  seg1;
        logic [SEG2_W-1:0]  seg2;
        logic [SJW_W-1:0]   sjw;
    } bit_timing_t;

    bit_timing_t          timing_q[$];
    logic [CLOCK_W-1:0]   clock_reg;

    initial begin
        pending    = 0;
        fail_count = 0;
        clock_reg  = CLOCK_W'(48000000);
    end

    function automatic bit_timing_t make_timing(input int unsigned p, input int unsigned s1,
                                                input int unsigned s2);
        bit_timing_t t;
        t.found = 1'b1;
        t.presc = PRESC_W'(p);
        t.seg1  = SEG1_W'(s1);
        t.seg2  = SEG2_W'(s2);
        t.sjw   = SJW_W'(1);
        return t;
    endfunction

    // fixed rate tables for the two known bus clocks
    function automatic bit_timing_t table_timing(input int unsigned clk, input int unsigned baud);
        bit_timing_t t;
        t = '0;
        if (clk == 48000000) begin
            case (baud)
                1000000: t = make_timing(3, 13, 2);
                800000:  t = make_timing(4, 12, 2);
                500000:  t = make_timing(6, 13, 2);
                250000:  t = make_timing(12, 13, 2);
                125000:  t = make_timing(24, 13, 2);
                100000:  t = make_timing(30, 13, 2);
                default: t = '0;
            endcase
        end else if (clk == 45000000) begin
            case (baud)
                1000000: t = make_timing(3, 12, 2);
                500000:  t = make_timing(5, 15, 2);
                250000:  t = make_timing(10, 15, 2);
                125000:  t = make_timing(20, 15, 2);
                100000:  t = make_timing(25, 15, 2);
                default: t = '0;
            endcase
        end
        return t;
    endfunction

    function automatic bit_timing_t predict_timing(input int unsigned clk, input int unsigned baud);
        bit_timing_t t;
        int unsigned div;
        t = table_timing(clk, baud);
        if (t.found)
            return t;
        // prescaler outer, seg2 middle, seg1 inner; first hit wins
        for (int unsigned p = 1; p <= MAX_PRESC; p++) begin
            for (int unsigned s2 = 1; s2 <= 3; s2++) begin
                for (int unsigned s1 = 5; s1 <= 15; s1++) begin
                    div = p * (1 + s1 + s2);
                    if (clk / div == baud)
                        return make_timing(p, s1, s2);
                end
            end
        end
        return '0;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        bit_timing_t want;
        if (!aresetn) begin
            clock_reg = CLOCK_W'(48000000);
        end else begin
            if (s_tvalid && s_tready)
                timing_q.push_back(predict_timing(clock_reg, s_tdata[BAUD_W-1:0]));
            if (m_tvalid && m_tready) begin
                if (timing_q.size() == 0) begin
                    $error("result beat with no request outstanding: tdata %h tuser %b",
                           m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = timing_q.pop_front();
                    check_field("found", want.found, m_tuser);
                    check_field("prescaler", want.presc, m_tdata[10:0]);
                    check_field("seg_one", want.seg1, m_tdata[15:11]);
                    check_field("seg_two", want.seg2, m_tdata[19:16]);
                    check_field("jump_width", want.sjw, m_tdata[22:20]);
                    check_field("tdata pad", 0, m_tdata[23]);
                end
            end
            if (cfg_wr_en)
                clock_reg = cfg_wr_data;
        end
        pending = timing_q.size();
    end

endmodule

// ===== bench/tb_can_bit_timing_search.sv =====
module tb_can_bit_timing_search;
    import cbts_pkg::*;

    localparam int MAX_PRESC   = MAX_PRESCALER_DEF;
    localparam int CYCLE_LIMIT = 20000000;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CLOCK_W-1:0]   cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [23:0]          m_tdata;
    logic                 m_tuser;

    int                   pending;
    int                   fail_count;
    logic                 calm        = 1'b0;
    int                   stall_left  = 0;
    int                   cycles      = 0;
    int unsigned          cur_clock   = 48000000;

    always #5 aclk = ~aclk;

    can_bit_timing_search #(.MAX_PRESCALER(MAX_PRESC)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    cbts_timing_checker #(.MAX_PRESC(MAX_PRESC)) chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .pending     (pending),
        .fail_count  (fail_count)
    );

    // receiver backpressure in bursts
    always @(negedge aclk) begin
        if (calm) begin
            m_tready = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready = 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            m_tready = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_rate(input int unsigned baud);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, BAUD_W'(baud)};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic set_clock(input int unsigned hz);
        wait_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = CLOCK_W'(hz);
        cur_clock   = hz;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    initial begin
        int unsigned phase_clock[7];
        int unsigned table_rates[6];
        int unsigned pick, p, s1, s2, rate;

        table_rates = '{1000000, 800000, 500000, 250000, 125000, 100000};
        phase_clock = '{48000000, 45000000, 268435455, 1, 0, 0, 48000000};
        phase_clock[4] = $urandom_range(268435455, 7);
        phase_clock[5] = $urandom_range(268435455, 7);

        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // reset clock is 48 MHz: table hits, edges of the rate range, misses
        foreach (table_rates[i]) send_rate(table_rates[i]);
        send_rate(0);
        send_rate(1);
        send_rate(3000000);
        send_rate(4000000);

        // 45 MHz table, plus a rate only in the 48 MHz table
        set_clock(45000000);
        for (int i = 0; i < 5; i++) send_rate(table_rates[i == 1 ? 5 : i]);
        send_rate(800000);

        // tiny clock: rate zero hits the first candidate
        set_clock(5);
        send_rate(0);
        send_rate(1);

        // zero clock: only rate zero can match
        set_clock(0);
        send_rate(0);
        send_rate(7);

        for (int ph = 0; ph < 7; ph++) begin
            set_clock(phase_clock[ph]);
            if (ph == 6)
                calm = 1'b1;
            for (int k = 0; k < 14; k++) begin
                pick = $urandom_range(0, 19);
                if (pick < 2) begin
                    rate = $urandom_range(0, 4000000);
                end else if (pick < 5) begin
                    rate = table_rates[$urandom_range(0, 5)];
                end else begin
                    // rate built from a real candidate, small prescalers mostly
                    s1 = $urandom_range(5, 15);
                    s2 = $urandom_range(1, 3);
                    p  = ($urandom_range(0, 19) == 0) ? $urandom_range(1, MAX_PRESC)
                                                      : $urandom_range(1, 32);
                    while (cur_clock / (p * (1 + s1 + s2)) > 4000000 && p < MAX_PRESC)
                        p = (p * 2 > MAX_PRESC) ? MAX_PRESC : p * 2;
                    rate = cur_clock / (p * (1 + s1 + s2));
                end
                send_rate(rate);
            end
        end

        wait_drained();
        repeat (40) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
